### rtl/core/sc_pkg.sv
// shared types and constants for the sortedness classifier
`timescale 1ns / 1ps
package sc_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FieldWidth = 17;
  localparam logic [ValueWidth-1:0] SignBias = 32'h8000_0000;
  localparam logic [FieldWidth-1:0] FieldMax = 17'h1FFFF;

  typedef enum logic [1:0] {
    STRAT_SIMPLE  = 2'd0,
    STRAT_MEDIUM  = 2'd1,
    STRAT_COMPLEX = 2'd2
  } strategy_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic [FieldWidth-1:0] inversions;
    logic [FieldWidth-1:0] pairs;
    logic [1:0]            strategy;
    logic                  overflow;
  } result_t;

  // beat travelling down the cell row
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  placed;
    logic [ValueWidth-1:0] key;
  } token_t;

endpackage

### rtl/core/sc_cell.sv
// one storage cell: holds a key, counts greater keys for passing beats
`timescale 1ns / 1ps
module sc_cell #(
  parameter int unsigned CW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  sc_pkg::token_t  tok_in,
  input  logic [CW-1:0]   gt_in,
  input  logic [CW-1:0]   seen_in,
  output sc_pkg::token_t  tok_out,
  output logic [CW-1:0]   gt_out,
  output logic [CW-1:0]   seen_out
);

  logic                          full;
  logic [sc_pkg::ValueWidth-1:0] key;
  logic                          hit;
  logic                          store;
  sc_pkg::token_t                tok_next;

  assign hit   = tok_in.valid && full && (key > tok_in.key);
  assign store = tok_in.valid && !full && !tok_in.placed;

  always_comb begin
    tok_next        = tok_in;
    tok_next.placed = tok_in.placed | store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (tok_in.valid && tok_in.last) begin
      full <= 1'b0;
    end else if (store) begin
      full <= 1'b1;
    end
    if (store) begin
      key <= tok_in.key;
    end
    tok_out.valid  <= tok_in.valid && !rst;
    tok_out.last   <= tok_next.last;
    tok_out.placed <= tok_next.placed;
    tok_out.key    <= tok_next.key;
    gt_out         <= gt_in + CW'(hit);
    seen_out       <= seen_in + CW'(full);
  end

endmodule

### rtl/core/sc_tally.sv
// end-of-row accumulator and classifier
`timescale 1ns / 1ps
module sc_tally #(
  parameter int unsigned CW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  sc_pkg::token_t  tok,
  input  logic [CW-1:0]   gt,
  input  logic [CW-1:0]   seen,
  output logic            done,
  output sc_pkg::result_t result
);

  localparam int unsigned TW = 2 * CW;
  localparam int unsigned SW = (TW > sc_pkg::FieldWidth) ? TW : sc_pkg::FieldWidth;

  logic [TW-1:0]   inv_total;
  logic [TW-1:0]   pair_total;
  logic            drop;
  logic [TW-1:0]   inv_total_next;
  logic [TW-1:0]   pair_total_next;
  logic            drop_next;
  logic [TW+2:0]   inv2;
  logic [TW+2:0]   inv5;
  logic [TW+2:0]   pairs_ext;
  logic [SW-1:0]   inv_wide;
  logic [SW-1:0]   pair_wide;
  sc_pkg::result_t result_next;

  always_comb begin
    if (tok.placed) begin
      inv_total_next  = inv_total + TW'(gt);
      pair_total_next = pair_total + TW'(seen);
      drop_next       = drop;
    end else begin
      inv_total_next  = inv_total;
      pair_total_next = pair_total;
      drop_next       = 1'b1;
    end
  end

  always_comb begin
    inv2      = (TW+3)'(inv_total_next) << 1;
    inv5      = ((TW+3)'(inv_total_next) << 2) + (TW+3)'(inv_total_next);
    pairs_ext = (TW+3)'(pair_total_next);
    inv_wide  = SW'(inv_total_next);
    pair_wide = SW'(pair_total_next);
    result_next.inversions = (inv_wide > SW'(sc_pkg::FieldMax)) ?
                             sc_pkg::FieldMax : inv_wide[sc_pkg::FieldWidth-1:0];
    result_next.pairs      = (pair_wide > SW'(sc_pkg::FieldMax)) ?
                             sc_pkg::FieldMax : pair_wide[sc_pkg::FieldWidth-1:0];
    result_next.overflow   = drop_next;
    priority if (pair_total_next == '0) begin
      result_next.strategy = sc_pkg::STRAT_SIMPLE;
    end else if (inv2 >= pairs_ext) begin
      result_next.strategy = sc_pkg::STRAT_COMPLEX;
    end else if (inv5 >= pairs_ext) begin
      result_next.strategy = sc_pkg::STRAT_MEDIUM;
    end else begin
      result_next.strategy = sc_pkg::STRAT_SIMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_total  <= '0;
      pair_total <= '0;
      drop       <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= tok.valid && tok.last;
      if (tok.valid) begin
        if (tok.last) begin
          inv_total  <= '0;
          pair_total <= '0;
          drop       <= 1'b0;
        end else begin
          inv_total  <= inv_total_next;
          pair_total <= pair_total_next;
          drop       <= drop_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok.valid && tok.last) begin
      result <= result_next;
    end
  end

endmodule

### rtl/core/sortedness_classifier.sv
// top level: row of comparator cells feeding the inversion tally
//
// Each beat on item is taken at a clock edge with start high and busy low; busy is only
// high in reset and in the cycle after it, so a beat can follow every cycle. A beat walks the row of
// MAX_ITEMS cells, one cell per cycle, counting held keys greater than its own and keeping
// its key in the first free cell. The beat marked last empties the cells as it passes and,
// once it has passed every cell and the tally register, done pulses for one cycle with the totals, the
// class and the overflow flag on result. The receiver must take the result in that cycle.
`timescale 1ns / 1ps
module sortedness_classifier #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sc_pkg::item_t   item,
  output logic            done,
  output sc_pkg::result_t result
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  sc_pkg::token_t tok  [0:MAX_ITEMS];
  logic [CW-1:0]  gt   [0:MAX_ITEMS];
  logic [CW-1:0]  seen [0:MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    tok[0].valid  = start && !busy;
    tok[0].last   = item.last;
    tok[0].placed = 1'b0;
    tok[0].key    = item.value ^ sc_pkg::SignBias;
    gt[0]         = '0;
    seen[0]       = '0;
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sc_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .gt_in    (gt[i]),
      .seen_in  (seen[i]),
      .tok_out  (tok[i+1]),
      .gt_out   (gt[i+1]),
      .seen_out (seen[i+1])
    );
  end

  sc_tally #(.CW(CW)) u_tally (
    .clk    (clk),
    .rst    (rst),
    .tok    (tok[MAX_ITEMS]),
    .gt     (gt[MAX_ITEMS]),
    .seen   (seen[MAX_ITEMS]),
    .done   (done),
    .result (result)
  );

endmodule

### rtl/core/sc_checker.sv
// port-level checks for the sortedness classifier
`timescale 1ns / 1ps
module sc_checker (
  input logic            clk,
  input logic            rst,
  input logic            busy,
  input logic            done,
  input sc_pkg::result_t result
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_strategy_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.strategy != 2'd3)
    else $error("strategy code out of range");

  a_inv_le_pairs: assert property (@(posedge clk) disable iff (rst)
    done |-> result.inversions <= result.pairs)
    else $error("more inversions than pairs");

  a_no_pairs_simple: assert property (@(posedge clk) disable iff (rst)
    (done && result.pairs == '0) |-> result.strategy == sc_pkg::STRAT_SIMPLE)
    else $error("nonzero class without pairs");

endmodule

bind sortedness_classifier sc_checker u_sc_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### dv/sortedness_classifier_checker.sv
// checker for the sortedness classifier: predicts each verdict and compares it with the result port
`timescale 1ns / 1ps
module sortedness_classifier_checker #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  sc_pkg::item_t   item,
  input  logic            done,
  input  sc_pkg::result_t result,
  output int unsigned     mismatches,
  output int unsigned     pending_count
);
  import sc_pkg::*;

  logic signed [ValueWidth-1:0] kept_values [MAX_ITEMS];
  int unsigned                  kept_count;
  longint unsigned              inversion_sum;
  longint unsigned              pair_sum;
  bit                           dropped;
  result_t                      pending_verdicts [$];
  int unsigned                  fail_count = 0;

  function automatic logic [FieldWidth-1:0] clip_field(input longint unsigned x);
    if (x > longint'(FieldMax)) return FieldMax;
    return x[FieldWidth-1:0];
  endfunction

  task automatic tally_item(input item_t beat);
    logic signed [ValueWidth-1:0] v;
    int unsigned                  greater;
    strategy_t                    cls;
    result_t                      verdict;
    v = beat.value;
    greater = 0;
    if (kept_count < MAX_ITEMS) begin
      for (int unsigned i = 0; i < kept_count; i++) begin
        if (kept_values[i] > v) greater++;
      end
      inversion_sum += greater;
      pair_sum += kept_count;
      kept_values[kept_count] = v;
      kept_count++;
    end else begin
      dropped = 1'b1;
    end
    if (beat.last) begin
      if (pair_sum == 0) cls = STRAT_SIMPLE;
      else if (inversion_sum * 2 >= pair_sum) cls = STRAT_COMPLEX;
      else if (inversion_sum * 5 >= pair_sum) cls = STRAT_MEDIUM;
      else cls = STRAT_SIMPLE;
      verdict.inversions = clip_field(inversion_sum);
      verdict.pairs = clip_field(pair_sum);
      verdict.strategy = cls;
      verdict.overflow = dropped;
      pending_verdicts = {pending_verdicts, verdict};
      kept_count = 0;
      inversion_sum = 0;
      pair_sum = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic compare_verdict(input result_t got);
    result_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result beat with no verdict pending: inversions %0d pairs %0d",
             got.inversions, got.pairs);
      fail_count++;
    end else begin
      want = pending_verdicts.pop_front();
      if (got.inversions !== want.inversions) begin
        $error("inversions: expected %0d, got %0d", want.inversions, got.inversions);
        fail_count++;
      end
      if (got.pairs !== want.pairs) begin
        $error("pairs: expected %0d, got %0d", want.pairs, got.pairs);
        fail_count++;
      end
      if (got.strategy !== want.strategy) begin
        $error("strategy: expected %0d, got %0d", want.strategy, got.strategy);
        fail_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kept_count = 0;
      inversion_sum = 0;
      pair_sum = 0;
      dropped = 1'b0;
    end else begin
      if (done) compare_verdict(result);
      if (start && !busy) tally_item(item);
    end
    mismatches <= fail_count;
    pending_count <= pending_verdicts.size();
  end

endmodule

### dv/sortedness_classifier_tb.sv
// testbench top for the sortedness classifier: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module sortedness_classifier_tb;
  import sc_pkg::*;

  localparam int unsigned MAX_ITEMS  = 512;
  localparam int unsigned Latency    = MAX_ITEMS + 2;
  localparam int unsigned StallLimit = 6000;
  localparam int unsigned ItemTarget = 1050;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_TIES,
    FILL_RISING,
    FILL_FALLING,
    FILL_EXTREMES
  } fill_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  int unsigned mismatches;
  int unsigned pending_count;
  int unsigned beats_sent = 0;
  int unsigned idle_cycles = 0;

  logic signed [ValueWidth-1:0] seq_vals [$];

  always #2 clk = ~clk;

  sortedness_classifier #(.MAX_ITEMS(MAX_ITEMS)) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  sortedness_classifier_checker #(.MAX_ITEMS(MAX_ITEMS)) verdict_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .done         (done),
    .result       (result),
    .mismatches   (mismatches),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_beat(input logic signed [ValueWidth-1:0] v, input logic l,
                           input bit steady);
    item_t       beat;
    int unsigned gap;
    beat.value = v;
    beat.last = l;
    start <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_seq(input bit steady);
    for (int i = 0; i < seq_vals.size(); i++) begin
      push_beat(seq_vals[i], i == seq_vals.size() - 1, steady);
    end
  endtask

  // hold off until every verdict has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic build_random_seq();
    int unsigned                  len;
    fill_t                        fill;
    logic signed [ValueWidth-1:0] run;
    logic signed [ValueWidth-1:0] v;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    fill = fill_t'($urandom_range(0, 4));
    run = $urandom;
    seq_vals.delete();
    for (int unsigned k = 0; k < len; k++) begin
      case (fill)
        FILL_RANDOM: begin
          v = $urandom;
        end
        FILL_TIES: begin
          v = $signed(32'($urandom_range(0, 6))) - 32'sd3;
        end
        FILL_RISING: begin
          run = run + $signed(32'($urandom_range(0, 5)));
          v = run;
        end
        FILL_FALLING: begin
          run = run - $signed(32'($urandom_range(0, 5)));
          v = run;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = 32'sh0000_0000;
            3: v = 32'shFFFF_FFFF;
            default: v = 32'sh0000_0001;
          endcase
        end
      endcase
      seq_vals = {seq_vals, v};
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single item, no pairs
    seq_vals = '{32'sh8000_0000};
    send_seq(1'b0);
    seq_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000};
    send_seq(1'b0);
    seq_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF};
    send_seq(1'b0);
    seq_vals = '{32'shFFFF_FFFF, 32'sh0000_0000};
    send_seq(1'b1);
    // equal values are not inversions
    seq_vals = '{32'sd5, 32'sd5};
    send_seq(1'b0);
    // complex class exactly at its boundary
    seq_vals = '{32'sd1, 32'sd4, 32'sd3, 32'sd2};
    send_seq(1'b0);
    // medium class exactly at its boundary
    seq_vals = '{32'sd2, 32'sd1, 32'sd3, 32'sd5, 32'sd4};
    send_seq(1'b1);
    seq_vals = '{32'sd1, 32'sd2, 32'sd3, 32'sd5, 32'sd4};
    send_seq(1'b0);
    drain();

    // full capacity, strictly falling, final beat dropped
    seq_vals.delete();
    for (int i = 0; i < MAX_ITEMS + 1; i++) seq_vals = {seq_vals, 32'sd1000 - i};
    send_seq($urandom_range(0, 1) == 0);
    drain();

    while (beats_sent < ItemTarget) begin
      build_random_seq();
      send_seq($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (Latency + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
